// File: src/traceparent_header_parser_assert.svh
// Assertion macros for the traceparent header parser.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef TRACEPARENT_HEADER_PARSER_ASSERT_SVH
`define TRACEPARENT_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define TPH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tph: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tph: next-cycle check failed");

`else

`define TPH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/tph_pkg.sv
// Shared types and constants for the traceparent header parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tph_pkg;

  localparam int unsigned POS_W = 6;

  // Layout positions (zero based) inside the header string
  localparam logic [POS_W-1:0] FULL_LENGTH   = 6'd55;
  localparam logic [POS_W-1:0] POS_VER_DASH  = 6'd2;
  localparam logic [POS_W-1:0] POS_TRACE_LO  = 6'd19;
  localparam logic [POS_W-1:0] POS_SPAN_DASH = 6'd35;
  localparam logic [POS_W-1:0] POS_FLAG_DASH = 6'd52;

  // Character codes
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // Pre-decoded character, held in the input stage
  typedef struct packed {
    logic [3:0] nibble;   // hex value, zero when not a hex digit
    logic       hex_ok;
    logic       zero_ch;
    logic       dash_ch;
    logic       last;
  } char_class_t;

  // One result item
  typedef struct packed {
    logic        ctx_valid;
    logic [63:0] trace_high;
    logic [63:0] trace_low;
    logic [63:0] span_value;
    logic [7:0]  flag_bits;
  } result_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             err;
  } accum_status_t;

endpackage

// File: src/tph_if.sv
// Valid/ready channel interfaces for the traceparent header parser.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface tph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface tph_out_if;
  logic        valid;
  logic        ready;
  logic        ctx_valid;
  logic [63:0] trace_high;
  logic [63:0] trace_low;
  logic [63:0] span_value;
  logic [7:0]  flag_bits;

  modport source (output valid, output ctx_valid, output trace_high, output trace_low,
                  output span_value, output flag_bits, input ready);
  modport sink   (input valid, input ctx_valid, input trace_high, input trace_low,
                  input span_value, input flag_bits, output ready);
endinterface

// File: src/tph_char_decode.sv
// Character classifier: hex value and layout classes of one input byte.
// Depends on tph_pkg.
`timescale 1ns / 1ps

module tph_char_decode (
  input  logic [7:0]          char_code,
  input  logic                is_last,
  output tph_pkg::char_class_t cls
);

  logic is_dec;
  logic is_lower;
  logic is_upper;

  // Classify the three hex ranges
  assign is_dec   = (char_code >= tph_pkg::CHAR_ZERO) && (char_code <= tph_pkg::CHAR_NINE);
  assign is_lower = (char_code >= tph_pkg::CHAR_LA) && (char_code <= tph_pkg::CHAR_LF);
  assign is_upper = (char_code >= tph_pkg::CHAR_UA) && (char_code <= tph_pkg::CHAR_UF);

  // Build the nibble; a non-hex byte shifts in zero
  always_comb begin
    cls.nibble = 4'd0;
    if (is_dec) begin
      cls.nibble = 4'(char_code - tph_pkg::CHAR_ZERO);
    end else if (is_lower) begin
      cls.nibble = 4'(char_code - tph_pkg::CHAR_LA + tph_pkg::HEX_TEN);
    end else if (is_upper) begin
      cls.nibble = 4'(char_code - tph_pkg::CHAR_UA + tph_pkg::HEX_TEN);
    end
    cls.hex_ok  = is_dec || is_lower || is_upper;
    cls.zero_ch = (char_code == tph_pkg::CHAR_ZERO);
    cls.dash_ch = (char_code == tph_pkg::CHAR_DASH);
    cls.last    = is_last;
  end

endmodule

// File: src/tph_field_accum.sv
// Position tracking, layout check and id shift registers of the parser.
// Depends on tph_pkg; gives the result of the string on its last item.
`timescale 1ns / 1ps

module tph_field_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,      // consume one item this cycle
  input  tph_pkg::char_class_t   cls,
  output tph_pkg::result_t       res,       // valid to take when step && cls.last
  output tph_pkg::accum_status_t status
);

  logic [tph_pkg::POS_W-1:0] pos_r, pos_upd, pos_nxt;
  logic                      err_r, err_upd, err_nxt;
  logic [63:0]               th_r, th_upd, th_nxt;
  logic [63:0]               tl_r, tl_upd, tl_nxt;
  logic [63:0]               sp_r, sp_upd, sp_nxt;
  logic [7:0]                fl_r, fl_upd, fl_nxt;
  logic                      in_window;
  logic                      ok;

  assign in_window = pos_r < tph_pkg::FULL_LENGTH;

  // Check the layout and shift the digit into its field
  always_comb begin
    pos_upd = pos_r;
    err_upd = err_r;
    th_upd  = th_r;
    tl_upd  = tl_r;
    sp_upd  = sp_r;
    fl_upd  = fl_r;
    if (step && in_window) begin
      if (pos_r < tph_pkg::POS_VER_DASH) begin
        if (!cls.zero_ch) err_upd = 1'b1;
      end else if (pos_r == tph_pkg::POS_VER_DASH || pos_r == tph_pkg::POS_SPAN_DASH ||
                   pos_r == tph_pkg::POS_FLAG_DASH) begin
        if (!cls.dash_ch) err_upd = 1'b1;
      end else begin
        if (!cls.hex_ok) err_upd = 1'b1;
        if (pos_r < tph_pkg::POS_TRACE_LO) begin
          th_upd = {th_r[59:0], cls.nibble};
        end else if (pos_r < tph_pkg::POS_SPAN_DASH) begin
          tl_upd = {tl_r[59:0], cls.nibble};
        end else if (pos_r < tph_pkg::POS_FLAG_DASH) begin
          sp_upd = {sp_r[59:0], cls.nibble};
        end else begin
          fl_upd = {fl_r[3:0], cls.nibble};
        end
      end
      pos_upd = pos_r + 1'b1;
    end
  end

  // Judge the string as it stands after this item
  assign ok = (pos_upd >= tph_pkg::FULL_LENGTH) && !err_upd &&
              ((th_upd | tl_upd) != 64'd0) && (sp_upd != 64'd0);

  always_comb begin
    res.ctx_valid  = ok;
    res.trace_high = ok ? th_upd : 64'd0;
    res.trace_low  = ok ? tl_upd : 64'd0;
    res.span_value = ok ? sp_upd : 64'd0;
    res.flag_bits  = ok ? fl_upd : 8'd0;
  end

  // Clear everything after the last item of a string
  always_comb begin
    pos_nxt = pos_upd;
    err_nxt = err_upd;
    th_nxt  = th_upd;
    tl_nxt  = tl_upd;
    sp_nxt  = sp_upd;
    fl_nxt  = fl_upd;
    if (step && cls.last) begin
      pos_nxt = '0;
      err_nxt = 1'b0;
      th_nxt  = '0;
      tl_nxt  = '0;
      sp_nxt  = '0;
      fl_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      err_r <= 1'b0;
      th_r  <= '0;
      tl_r  <= '0;
      sp_r  <= '0;
      fl_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      err_r <= err_nxt;
      th_r  <= th_nxt;
      tl_r  <= tl_nxt;
      sp_r  <= sp_nxt;
      fl_r  <= fl_nxt;
    end
  end

  assign status.pos = pos_r;
  assign status.err = err_r;

endmodule

// File: src/tph_result_reg.sv
// Output register of the parser: holds one result item until taken.
// Depends on tph_pkg.
`timescale 1ns / 1ps

module tph_result_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tph_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             slot_free,
  output logic             out_valid,
  output tph_pkg::result_t out_data
);

  logic             valid_r, valid_nxt;
  tph_pkg::result_t data_r, data_nxt;

  // Free when empty or when the held item leaves this cycle
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: src/traceparent_header_parser.sv
// Streaming traceparent header parser, top level.
// Depends on tph_pkg, tph_if, tph_char_decode, tph_field_accum, tph_result_reg
// and the assertion macros in traceparent_header_parser_assert.svh.
//
// Usage:
//   in_if carries the header string, one ASCII byte per item, with is_last
//   set on the final byte. out_if carries one result item per string: the
//   trace id halves, span id and flags byte with ctx_valid set, or all zeros
//   with ctx_valid clear when the layout is wrong, the string is shorter than
//   55 bytes or an id is zero. Bytes past the 55th are not checked.
//   An item is taken when valid and ready are both high at a clock edge.
//   The result of a last byte passes through the input register and then the
//   output register before it shows on out_if.
//   Throughput: one byte per cycle unless a last byte waits for the output
//   register; decode sits before the input register, field update after it.
//   When out_if stalls, bytes that are not last keep flowing; a last byte
//   waits in the input register until the output register has room.
//   Reset (rst_n low, synchronous) empties both registers and starts a new
//   string.
`timescale 1ns / 1ps
`include "traceparent_header_parser_assert.svh"

module traceparent_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  tph_in_if.sink     in_if,
  tph_out_if.source  out_if
);

  tph_pkg::char_class_t   dec_cls;
  tph_pkg::char_class_t   s1_cls_r, s1_cls_nxt;
  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_step;
  logic                   in_take;
  logic                   slot_free;
  tph_pkg::result_t       acc_res;
  tph_pkg::result_t       out_data;
  tph_pkg::accum_status_t acc_status;
  logic                   out_valid;

  // Classify the incoming byte
  tph_char_decode u_decode (
    .char_code (in_if.char_code),
    .is_last   (in_if.is_last),
    .cls       (dec_cls)
  );

  // Advance the held item unless it is a last byte facing a full output
  assign s1_step = s1_valid_r && (!s1_cls_r.last || slot_free);
  assign in_if.ready = !s1_valid_r || s1_step;
  assign in_take = in_if.valid && in_if.ready;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_cls_nxt   = s1_cls_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_cls_nxt   = dec_cls;
    end else if (s1_step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cls_r <= s1_cls_nxt;
  end

  // Layout check and id accumulation
  tph_field_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_step),
    .cls    (s1_cls_r),
    .res    (acc_res),
    .status (acc_status)
  );

  // Output register
  tph_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_step && s1_cls_r.last),
    .load_data (acc_res),
    .out_ready (out_if.ready),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_if.valid      = out_valid;
  assign out_if.ctx_valid  = out_data.ctx_valid;
  assign out_if.trace_high = out_data.trace_high;
  assign out_if.trace_low  = out_data.trace_low;
  assign out_if.span_value = out_data.span_value;
  assign out_if.flag_bits  = out_data.flag_bits;

  // Checks
  `TPH_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_step && s1_cls_r.last, out_if.valid)
  `TPH_ASSERT_NEXT(a_last_clears_pos, clk, rst_n, s1_step && s1_cls_r.last, acc_status.pos == '0 && !acc_status.err)
  `TPH_ASSERT_IMPL(a_invalid_is_zero, clk, rst_n, out_if.valid && !out_if.ctx_valid, out_if.trace_high == 64'd0 && out_if.trace_low == 64'd0 && out_if.span_value == 64'd0 && out_if.flag_bits == 8'd0)
  `TPH_ASSERT_IMPL(a_valid_ids_nonzero, clk, rst_n, out_if.valid && out_if.ctx_valid, out_if.span_value != 64'd0 && (out_if.trace_high != 64'd0 || out_if.trace_low != 64'd0))

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for traceparent_header_parser: streams header strings one byte per item
// and checks every result item against a parser model kept inside the bench.
// Depends on tph_pkg, the tph_in_if / tph_out_if interfaces and the parser RTL.

module tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_GAP      = 60;

  typedef logic [7:0] char_q_t[$];
  typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} digit_case_t;

  logic clk = 1'b0;
  logic rst_n;

  tph_in_if  in_ch();
  tph_out_if out_ch();

  traceparent_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Parser model state
  logic [tph_pkg::POS_W-1:0] hdr_pos;
  logic                      hdr_err;
  logic [63:0]               hdr_trace_hi;
  logic [63:0]               hdr_trace_lo;
  logic [63:0]               hdr_span;
  logic [7:0]                hdr_flags;

  // Contexts still owed by the parser, oldest first
  tph_pkg::result_t pending_ctx[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int errors        = 0;
  int chars_sent    = 0;
  int strings_sent  = 0;
  int results_seen  = 0;
  int valid_seen    = 0;
  int cycle_count   = 0;

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Drive out ready: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endfunction

  // Compare each accepted result item with the oldest pending context
  always @(posedge clk) begin : check_results
    tph_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.ctx_valid) valid_seen++;
      if (pending_ctx.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual ctx_valid %b %h %h %h %h",
                 $time, out_ch.ctx_valid, out_ch.trace_high, out_ch.trace_low,
                 out_ch.span_value, out_ch.flag_bits);
      end else begin
        want = pending_ctx.pop_front();
        check_field("ctx_valid",  want.ctx_valid,  out_ch.ctx_valid);
        check_field("trace_high", want.trace_high, out_ch.trace_high);
        check_field("trace_low",  want.trace_low,  out_ch.trace_low);
        check_field("span_value", want.span_value, out_ch.span_value);
        check_field("flag_bits",  want.flag_bits,  out_ch.flag_bits);
      end
    end
  end

  task automatic clear_header();
    hdr_pos      = '0;
    hdr_err      = 1'b0;
    hdr_trace_hi = '0;
    hdr_trace_lo = '0;
    hdr_span     = '0;
    hdr_flags    = '0;
  endtask

  // Advance the parser model by one character; on the last one queue its context
  task automatic parse_char(input logic [7:0] ch, input logic last);
    logic [3:0]       nib;
    logic             hex_ok;
    tph_pkg::result_t ctx;
    hex_ok = 1'b1;
    if (ch >= tph_pkg::CHAR_ZERO && ch <= tph_pkg::CHAR_NINE) begin
      nib = 4'(ch - tph_pkg::CHAR_ZERO);
    end else if (ch >= tph_pkg::CHAR_LA && ch <= tph_pkg::CHAR_LF) begin
      nib = 4'(ch - tph_pkg::CHAR_LA + tph_pkg::HEX_TEN);
    end else if (ch >= tph_pkg::CHAR_UA && ch <= tph_pkg::CHAR_UF) begin
      nib = 4'(ch - tph_pkg::CHAR_UA + tph_pkg::HEX_TEN);
    end else begin
      nib    = 4'd0;
      hex_ok = 1'b0;
    end
    // Characters past the fixed layout are ignored
    if (hdr_pos < tph_pkg::FULL_LENGTH) begin
      if (hdr_pos < tph_pkg::POS_VER_DASH) begin
        if (ch != tph_pkg::CHAR_ZERO) hdr_err = 1'b1;
      end else if (hdr_pos == tph_pkg::POS_VER_DASH || hdr_pos == tph_pkg::POS_SPAN_DASH ||
                   hdr_pos == tph_pkg::POS_FLAG_DASH) begin
        if (ch != tph_pkg::CHAR_DASH) hdr_err = 1'b1;
      end else begin
        if (!hex_ok) hdr_err = 1'b1;
        if (hdr_pos < tph_pkg::POS_TRACE_LO) hdr_trace_hi = {hdr_trace_hi[59:0], nib};
        else if (hdr_pos < tph_pkg::POS_SPAN_DASH) hdr_trace_lo = {hdr_trace_lo[59:0], nib};
        else if (hdr_pos < tph_pkg::POS_FLAG_DASH) hdr_span = {hdr_span[59:0], nib};
        else hdr_flags = {hdr_flags[3:0], nib};
      end
      hdr_pos = hdr_pos + 1'b1;
    end
    if (last) begin
      ctx = '0;
      if (hdr_pos >= tph_pkg::FULL_LENGTH && !hdr_err &&
          (hdr_trace_hi | hdr_trace_lo) != 0 && hdr_span != 0) begin
        ctx.ctx_valid  = 1'b1;
        ctx.trace_high = hdr_trace_hi;
        ctx.trace_low  = hdr_trace_lo;
        ctx.span_value = hdr_span;
        ctx.flag_bits  = hdr_flags;
      end
      pending_ctx = {pending_ctx, ctx};
      clear_header();
    end
  endtask

  // Offer one character item after a random idle gap and hold it until taken
  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= ch;
    in_ch.is_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  // Drop valid and wait until every pending context has come back
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (pending_ctx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] nib, digit_case_t mode);
    logic upper;
    upper = (mode == CASE_UPPER) || (mode == CASE_MIXED && $urandom_range(1) == 1);
    if (nib < tph_pkg::HEX_TEN) return tph_pkg::CHAR_ZERO + nib;
    return (upper ? tph_pkg::CHAR_UA : tph_pkg::CHAR_LA) + (nib - tph_pkg::HEX_TEN);
  endfunction

  // Format a well-formed 55 character header
  function automatic char_q_t build_header(logic [63:0] hi, logic [63:0] lo,
                                           logic [63:0] span, logic [7:0] flags,
                                           digit_case_t mode);
    char_q_t      s;
    logic [127:0] trace;
    trace = {hi, lo};
    s = {tph_pkg::CHAR_ZERO, tph_pkg::CHAR_ZERO, tph_pkg::CHAR_DASH};
    for (int i = 31; i >= 0; i--) s = {s, hex_digit(trace[i*4 +: 4], mode)};
    s = {s, tph_pkg::CHAR_DASH};
    for (int i = 15; i >= 0; i--) s = {s, hex_digit(span[i*4 +: 4], mode)};
    s = {s, tph_pkg::CHAR_DASH};
    for (int i = 1; i >= 0; i--) s = {s, hex_digit(flags[i*4 +: 4], mode)};
    return s;
  endfunction

  function automatic logic [63:0] random_id();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return 64'($urandom_range(15));
    if (pick < 25) return '1;
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed headers with random content, the rest broken or noise
  function automatic char_q_t random_string();
    char_q_t     s;
    int          kind;
    int          len;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] span;
    kind = $urandom_range(99);
    hi   = random_id();
    lo   = random_id();
    span = random_id();
    if (kind >= 62 && kind < 72) begin
      if ($urandom_range(1) == 1) begin
        hi = '0;
        lo = '0;
      end else begin
        span = '0;
      end
    end
    s = build_header(hi, lo, span, 8'($urandom_range(255)), digit_case_t'($urandom_range(2)));
    if (kind >= 50 && kind < 62) begin
      s[$urandom_range(54)] = 8'($urandom_range(255));
    end else if (kind >= 72 && kind < 80) begin
      repeat ($urandom_range(1, 12)) s = {s, 8'($urandom_range(255))};
    end else if (kind >= 80 && kind < 90) begin
      len = $urandom_range(1, 54);
      while (s.size() > len) void'(s.pop_back());
    end else if (kind >= 90) begin
      s = {};
      repeat ($urandom_range(1, 70)) s = {s, 8'($urandom_range(255))};
    end
    return s;
  endfunction

  task automatic test_valid_headers();
    send_string(build_header(64'h0af7651916cd43dd, 64'h8448eb211c80319c,
                             64'hb7ad6b7169203331, 8'h01, CASE_LOWER));
    send_string(build_header('1, '1, '1, 8'hFF, CASE_UPPER));
    send_string(build_header(64'h0123456789abcdef, 64'hfedcba9876543210,
                             64'habcdef0123456789, 8'h5A, CASE_MIXED));
    wait_results();
  endtask

  task automatic test_zero_ids();
    send_string(build_header(64'h0, 64'h0, 64'h1234, 8'h01, CASE_LOWER));
    send_string(build_header(64'h1, 64'h2, 64'h0, 8'h01, CASE_LOWER));
    wait_results();
  endtask

  task automatic test_short_strings();
    char_q_t s;
    s = {tph_pkg::CHAR_ZERO};
    send_string(s);
    s = {8'hFF};
    send_string(s);
    s = {tph_pkg::CHAR_ZERO, tph_pkg::CHAR_ZERO, tph_pkg::CHAR_DASH};
    send_string(s);
    s = build_header(64'h1, 64'h1, 64'h1, 8'h01, CASE_LOWER);
    void'(s.pop_back());
    send_string(s);
    wait_results();
  endtask

  task automatic test_long_strings();
    char_q_t s;
    s = build_header(64'hdeadbeefcafef00d, 64'h1, 64'h77, 8'h03, CASE_MIXED);
    s = {s, tph_pkg::CHAR_DASH, 8'hFF, 8'h00};
    repeat (17) s = {s, 8'($urandom_range(255))};
    send_string(s);
    wait_results();
  endtask

  // One bad character per header, around the layout boundaries
  task automatic test_bad_chars();
    int         bad_pos[6] = '{0, 2, 18, 35, 36, 54};
    logic [7:0] bad_ch[6]  = '{"1", "_", "G", tph_pkg::CHAR_ZERO, "/", 8'hFF};
    char_q_t    s;
    foreach (bad_pos[i]) begin
      s = build_header(64'h1111, 64'h2222, 64'h3333, 8'h01, CASE_LOWER);
      s[bad_pos[i]] = bad_ch[i];
      send_string(s);
    end
    wait_results();
  endtask

  // Hold off the output long enough that last-character items back up the input
  task automatic test_output_backpressure();
    char_q_t s;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_seq++;
    s = {tph_pkg::CHAR_ZERO};
    repeat (10) send_string(s);
    send_string(build_header(64'h42, 64'h43, 64'h44, 8'h01, CASE_UPPER));
    wait_results();
  endtask

  task automatic test_random_phase(int idle_pct, int stall, int min_chars, int min_strings);
    int start_chars;
    int start_strings;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    start_chars   = chars_sent;
    start_strings = strings_sent;
    while (chars_sent - start_chars < min_chars || strings_sent - start_strings < min_strings)
      send_string(random_string());
    wait_results();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.is_last   <= 1'b0;
    clear_header();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    stall_pct     = 20;
    test_valid_headers();
    test_zero_ids();
    test_short_strings();
    test_long_strings();
    test_bad_chars();
    test_output_backpressure();

    test_random_phase(0, 0, 60, 1);
    test_random_phase(81, 0, 60, 1);
    test_random_phase(0, 81, 60, 1);
    test_random_phase(6, 6, 60, 1);

    $display("covered %0d header strings (%0d characters) over four idle mixes",
             strings_sent, chars_sent);
    $display("checked %0d results, %0d with a valid context, one long output hold-off",
             results_seen, valid_seen);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
